// ===== rtl/mmce_pkg.sv =====
// Shared types, constants and the CRC byte-step function for the
// multi-mode checksum engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmce_pkg;

   localparam logic [15:0] DEFAULT_POLY = 16'd33800;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

   localparam logic [1:0] MODE_CRC16    = 2'd0;
   localparam logic [1:0] MODE_WORD_SUM = 2'd1;
   localparam logic [1:0] MODE_BYTE_SUM = 2'd2;

   localparam int          CSR_ADDR_W = 3;
   localparam logic        REG_MODE   = 1'b0;
   localparam logic        REG_POLY   = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] poly;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] checksum;
   } result_type;

   // One byte of a reflected CRC-16, bit at a time.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_prev,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc_prev ^ {8'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mmce_csr.sv =====
// Configuration registers behind the APB-style port.
// Depends on mmce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmce_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mmce_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic      [31:0]                      csr_prdata,
   output logic                                  csr_pready,
   output mmce_pkg::cfg_type                     cfg
);
   import mmce_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] poly_ff, poly_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      mode_in = mode_ff;
      poly_in = poly_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MODE: mode_in = csr_pwdata[1:0];
            REG_POLY: poly_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CRC16;
         poly_ff <= 16'd0;
      end else begin
         mode_ff <= mode_in;
         poly_ff <= poly_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MODE: csr_prdata = {30'd0, mode_ff};
         REG_POLY: csr_prdata = {16'd0, poly_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   assign cfg.mode = mode_ff;
   assign cfg.poly = poly_ff;

endmodule

`default_nettype wire

// ===== rtl/mmce_accum.sv =====
// Running accumulators (CRC-16, word sums, byte sum) and final result select.
// Depends on mmce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmce_accum (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              last_byte,
   input  mmce_pkg::cfg_type      cfg,
   output mmce_pkg::result_type   result
);
   import mmce_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [15:0] wsum_ff, wsum_in;
   logic [15:0] isum_ff, isum_in;
   logic [31:0] btot_ff, btot_in;
   logic [7:0]  held_ff, held_in;
   logic        odd_ff, odd_in;

   logic [15:0] poly;
   logic [15:0] crc_nx, wsum_nx, isum_nx, word, hi, lo;
   logic [31:0] btot_nx;

   assign poly    = (cfg.poly == 16'd0) ? DEFAULT_POLY : cfg.poly;
   assign crc_nx  = crc_byte(crc_ff, data_byte, poly);
   assign btot_nx = btot_ff + {24'd0, data_byte};
   assign word    = {held_ff, data_byte};
   assign wsum_nx = odd_ff ? wsum_ff + word : wsum_ff;
   assign isum_nx = odd_ff ? isum_ff + ~word : isum_ff;
   assign hi      = (wsum_nx == SUM_ALL_ONES) ? 16'd0 : wsum_nx;
   assign lo      = (isum_nx == SUM_ALL_ONES) ? 16'd0 : isum_nx;

   always_comb begin
      case (cfg.mode)
         MODE_CRC16:    result.checksum = {16'd0, ~crc_nx};
         MODE_WORD_SUM: result.checksum = {hi, lo};
         MODE_BYTE_SUM: result.checksum = btot_nx;
         default:       result.checksum = 32'd0;
      endcase
   end
   assign result.valid = item_accept & last_byte;

   always_comb begin
      crc_in  = crc_ff;
      wsum_in = wsum_ff;
      isum_in = isum_ff;
      btot_in = btot_ff;
      held_in = held_ff;
      odd_in  = odd_ff;
      if (item_accept) begin
         if (last_byte) begin
            crc_in  = CRC_INIT;
            wsum_in = 16'd0;
            isum_in = 16'd0;
            btot_in = 32'd0;
            held_in = 8'd0;
            odd_in  = 1'b0;
         end else begin
            crc_in  = crc_nx;
            wsum_in = wsum_nx;
            isum_in = isum_nx;
            btot_in = btot_nx;
            held_in = odd_ff ? held_ff : data_byte;
            odd_in  = ~odd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         wsum_ff <= 16'd0;
         isum_ff <= 16'd0;
         btot_ff <= 32'd0;
         held_ff <= 8'd0;
         odd_ff  <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         wsum_ff <= wsum_in;
         isum_ff <= isum_in;
         btot_ff <= btot_in;
         held_ff <= held_in;
         odd_ff  <= odd_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mmce_out.sv =====
// Result register on the output stream; gives upstream ready.
// Depends on mmce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmce_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  mmce_pkg::result_type   result,
   output logic                   take_ready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata
);
   import mmce_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;

   assign take_ready = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take_ready) begin
         valid_in = result.valid;
         if (result.valid) begin
            data_in = result.checksum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/multi_mode_checksum_engine_top.sv =====
// Top level of the multi-mode checksum engine: CSR block, accumulators, result register.
// Depends on mmce_pkg, mmce_csr, mmce_accum, mmce_out.
//
// Takes one message byte per cycle (one item per clock when rsp_tready is high);
// the checksum for a message appears on rsp_* in the cycle after the byte with
// req_tlast is accepted. The single result register sets the rate: req_tready
// drops only while a finished checksum waits in it and rsp_tready is low.
// Mode 0 gives the inverted reflected CRC-16 (zero-extended), mode 1 the
// word sum (high half) and sum of inverted words (low half), mode 2 the byte sum,
// mode 3 zero. Write configuration only while no message is in progress.
`timescale 1ns / 1ps
`default_nettype none

module multi_mode_checksum_engine_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [31:0]                      rsp_tdata,   // [31:0] checksum
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mmce_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic      [31:0]                      csr_prdata,
   output logic                                  csr_pready
);
   import mmce_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       item_accept;

   assign item_accept = req_tvalid & req_tready;

   mmce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mmce_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .cfg         (cfg),
      .result      (result)
   );

   mmce_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .take_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== rtl/mmce_checker.sv =====
// Port-level checks for the checksum engine, bound to the top level.
// Depends on multi_mode_checksum_engine_top.
`timescale 1ns / 1ps
`default_nettype none

module mmce_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             req_tlast,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [31:0]                      rsp_tdata
);
   logic last_accept;
   assign last_accept = req_tvalid & req_tready & req_tlast;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(last_accept))
      else $error("result without a final byte");

   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !last_accept) |=> !rsp_tvalid)
      else $error("result repeated");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind multi_mode_checksum_engine_top mmce_checker u_mmce_checker (.*);

`default_nettype wire
